### hw/rtl/icz_pkg.sv
// ============================================================================
// icz_pkg
// Shared types and fixed constants of the zero-padded 3D image convolver.
// ============================================================================
package icz_pkg;

    // Configuration register indexes (byte address is 4 * index)
    localparam logic [2:0] REG_KSIZE_X  = 3'd0;
    localparam logic [2:0] REG_KSIZE_Y  = 3'd1;
    localparam logic [2:0] REG_KSIZE_Z  = 3'd2;
    localparam logic [2:0] REG_WIDTH    = 3'd3;
    localparam logic [2:0] REG_HEIGHT   = 3'd4;
    localparam logic [2:0] REG_DEPTH    = 3'd5;

    // Item modes
    localparam logic [1:0] MODE_COEF  = 2'd0;
    localparam logic [1:0] MODE_PIXEL = 2'd1;
    localparam logic [1:0] MODE_FLUSH = 2'd2;

    // Fixed field and storage widths
    localparam int ADDR_W     = 5;
    localparam int KS_W       = 3;
    localparam int DIM_W      = 7;
    localparam int DEPTH_W    = 13;
    localparam int PLANE_W    = 14;
    localparam int TOTAL_W    = 27;
    localparam int POS_W      = 28;
    localparam int OFS_W      = 17;
    localparam int CIDX_W     = 9;
    localparam int COEF_IN_W  = 16;
    localparam int COEF_W     = 17;
    localparam int RING_AW    = 15;
    localparam int RING_DEPTH = 32768;

    // Volume geometry derived from the configuration registers
    typedef struct packed {
        logic [KS_W-1:0]    sx;
        logic [KS_W-1:0]    sy;
        logic [KS_W-1:0]    sz;
        logic [1:0]         hx;
        logic [1:0]         hy;
        logic [1:0]         hz;
        logic [DIM_W-1:0]   w;
        logic [DIM_W-1:0]   h;
        logic [DEPTH_W-1:0] d;
        logic [PLANE_W-1:0] plane;
        logic [TOTAL_W-1:0] total_m1;
        logic [OFS_W-1:0]   back;
        logic [OFS_W-1:0]   reach;
    } icz_geom_t;

    // Memory write strobes and addresses
    typedef struct packed {
        logic               ring_we;
        logic [RING_AW-1:0] ring_addr;
        logic               coef_we;
        logic [CIDX_W-1:0]  coef_addr;
    } icz_wr_t;

    // One kernel tap read
    typedef struct packed {
        logic               live;
        logic [RING_AW-1:0] ring_addr;
        logic [CIDX_W-1:0]  coef_addr;
    } icz_tap_t;

    // Accumulator control
    typedef struct packed {
        logic acc_clear;
        logic live;
    } icz_mac_ctl_t;

endpackage

### hw/rtl/icz_cfg.sv
// ============================================================================
// icz_cfg
// APB register file and registered geometry derivation.
// ============================================================================
module icz_cfg #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [icz_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output logic                        cfg_wr,
    output icz_pkg::icz_geom_t          geom
);
    import icz_pkg::*;

    localparam logic [10:0] CAP_W = 11'(MAX_WIDTH);
    localparam logic [10:0] CAP_H = 11'(MAX_HEIGHT);

    logic [KS_W-1:0]    ksx_reg, ksy_reg, ksz_reg;
    logic [DIM_W-1:0]   width_reg, height_reg;
    logic [DEPTH_W-1:0] depth_reg;
    logic [2:0]         idx;
    logic               wr_en;

    logic [DIM_W-1:0]   wc, hc;
    logic [DEPTH_W-1:0] dc;
    logic [1:0]         hxc, hyc, hzc, fxc, fyc, fzc;

    // stage A
    logic [DIM_W-1:0]   w_a_reg, h_a_reg;
    logic [DEPTH_W-1:0] d_a_reg;
    logic [PLANE_W-1:0] plane_a_reg;
    logic [8:0]         hyw_a_reg, fyw_a_reg;
    logic [1:0]         hx_a_reg, hy_a_reg, hz_a_reg, fx_a_reg, fz_a_reg;
    // stage B
    logic [TOTAL_W-1:0] total_b_reg;
    logic [15:0]        hzp_b_reg, fzp_b_reg;
    logic [9:0]         hxy_b_reg, fxy_b_reg;
    // stage C
    logic [TOTAL_W-1:0] total_m1_c_reg;
    logic [OFS_W-1:0]   back_c_reg, reach_c_reg;

    assign idx    = paddr[4:2];
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg_wr = wr_en && (idx == REG_KSIZE_X || idx == REG_KSIZE_Y ||
                              idx == REG_KSIZE_Z || idx == REG_WIDTH ||
                              idx == REG_HEIGHT  || idx == REG_DEPTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ksx_reg    <= 3'd3;
            ksy_reg    <= 3'd3;
            ksz_reg    <= 3'd1;
            width_reg  <= 7'd64;
            height_reg <= 7'd64;
            depth_reg  <= 13'd1;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_KSIZE_X: ksx_reg    <= pwdata[KS_W-1:0];
                REG_KSIZE_Y: ksy_reg    <= pwdata[KS_W-1:0];
                REG_KSIZE_Z: ksz_reg    <= pwdata[KS_W-1:0];
                REG_WIDTH:   width_reg  <= pwdata[DIM_W-1:0];
                REG_HEIGHT:  height_reg <= pwdata[DIM_W-1:0];
                REG_DEPTH:   depth_reg  <= pwdata[DEPTH_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_KSIZE_X: prdata = 32'(ksx_reg);
            REG_KSIZE_Y: prdata = 32'(ksy_reg);
            REG_KSIZE_Z: prdata = 32'(ksz_reg);
            REG_WIDTH:   prdata = 32'(width_reg);
            REG_HEIGHT:  prdata = 32'(height_reg);
            REG_DEPTH:   prdata = 32'(depth_reg);
            default:     prdata = 32'd0;
        endcase
    end

    // clip extents: zero counts as one, oversize width and height as the cap
    always_comb
    begin
        if (width_reg == '0)
            wc = 7'd1;
        else if (11'(width_reg) > CAP_W)
            wc = CAP_W[DIM_W-1:0];
        else
            wc = width_reg;
        if (height_reg == '0)
            hc = 7'd1;
        else if (11'(height_reg) > CAP_H)
            hc = CAP_H[DIM_W-1:0];
        else
            hc = height_reg;
        dc  = (depth_reg == '0) ? 13'd1 : depth_reg;
        hxc = ksx_reg[2:1];
        hyc = ksy_reg[2:1];
        hzc = ksz_reg[2:1];
        fxc = (ksx_reg == '0) ? 2'd0 : 2'(ksx_reg - 3'd1 - 3'(ksx_reg[2:1]));
        fyc = (ksy_reg == '0) ? 2'd0 : 2'(ksy_reg - 3'd1 - 3'(ksy_reg[2:1]));
        fzc = (ksz_reg == '0) ? 2'd0 : 2'(ksz_reg - 3'd1 - 3'(ksz_reg[2:1]));
    end

    always_ff @(posedge clk)
    begin
        w_a_reg        <= wc;
        h_a_reg        <= hc;
        d_a_reg        <= dc;
        plane_a_reg    <= 14'(wc * hc);
        hyw_a_reg      <= 9'(hyc * wc);
        fyw_a_reg      <= 9'(fyc * wc);
        hx_a_reg       <= hxc;
        hy_a_reg       <= hyc;
        hz_a_reg       <= hzc;
        fx_a_reg       <= fxc;
        fz_a_reg       <= fzc;
        total_b_reg    <= 27'(plane_a_reg * d_a_reg);
        hzp_b_reg      <= 16'(hz_a_reg * plane_a_reg);
        fzp_b_reg      <= 16'(fz_a_reg * plane_a_reg);
        hxy_b_reg      <= 10'(hyw_a_reg) + 10'(hx_a_reg);
        fxy_b_reg      <= 10'(fyw_a_reg) + 10'(fx_a_reg);
        total_m1_c_reg <= total_b_reg - 27'd1;
        back_c_reg     <= 17'(hzp_b_reg) + 17'(hxy_b_reg);
        reach_c_reg    <= 17'(fzp_b_reg) + 17'(fxy_b_reg);
    end

    always_comb
    begin
        geom.sx       = ksx_reg;
        geom.sy       = ksy_reg;
        geom.sz       = ksz_reg;
        geom.hx       = hx_a_reg;
        geom.hy       = hy_a_reg;
        geom.hz       = hz_a_reg;
        geom.w        = w_a_reg;
        geom.h        = h_a_reg;
        geom.d        = d_a_reg;
        geom.plane    = plane_a_reg;
        geom.total_m1 = total_m1_c_reg;
        geom.back     = back_c_reg;
        geom.reach    = reach_c_reg;
    end

endmodule

### hw/rtl/icz_store.sv
// ============================================================================
// icz_store
// Sample ring and coefficient memory, both with registered reads.
// ============================================================================
module icz_store #(
    parameter int KERNEL_MAX = 7,
    parameter int COEF_FRAC  = 12,
    parameter int PIXEL_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  icz_pkg::icz_wr_t                 wr,
    input  logic [PIXEL_BITS-1:0]            ring_wd,
    input  logic [icz_pkg::COEF_IN_W-1:0]    coef_wd,
    input  icz_pkg::icz_tap_t                tap,
    output logic [PIXEL_BITS-1:0]            ring_q,
    output logic [icz_pkg::COEF_W-1:0]       coef_q,
    output logic                             live_q,
    output logic                             clr_busy
);
    import icz_pkg::*;

    localparam int COEF_DEPTH = KERNEL_MAX * KERNEL_MAX * KERNEL_MAX;
    localparam int CA_W       = $clog2(COEF_DEPTH);
    localparam logic [CA_W-1:0] LAST_ADDR = CA_W'(COEF_DEPTH - 1);
    localparam logic [CA_W-1:0] UNIT_ADDR = CA_W'(4);
    localparam logic [COEF_W-1:0] UNIT_VAL = COEF_W'(1) << COEF_FRAC;

    logic [PIXEL_BITS-1:0] ring_mem [RING_DEPTH];
    logic [COEF_W-1:0]     coef_mem [COEF_DEPTH];
    logic                  clr_busy_reg;
    logic [CA_W-1:0]       clr_addr_reg;

    assign clr_busy = clr_busy_reg;

    // clearing pass: rewrite the reset kernel, one entry per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            live_q       <= 1'b0;
        end
        else
        begin
            live_q <= tap.live;
            if (clr_busy_reg)
            begin
                if (clr_addr_reg == LAST_ADDR)
                    clr_busy_reg <= 1'b0;
                clr_addr_reg <= clr_addr_reg + CA_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
            coef_mem[clr_addr_reg] <= (clr_addr_reg == UNIT_ADDR) ? UNIT_VAL : '0;
        else if (wr.coef_we)
            coef_mem[wr.coef_addr[CA_W-1:0]] <=
                {{(COEF_W-COEF_IN_W){coef_wd[COEF_IN_W-1]}}, coef_wd};
        coef_q <= coef_mem[tap.coef_addr[CA_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (wr.ring_we)
            ring_mem[wr.ring_addr] <= ring_wd;
        ring_q <= ring_mem[tap.ring_addr];
    end

endmodule

### hw/rtl/icz_mac.sv
// ============================================================================
// icz_mac
// Multiply-accumulate of kernel taps, then scale, truncate and saturate.
// ============================================================================
module icz_mac #(
    parameter int COEF_FRAC  = 12,
    parameter int PIXEL_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  icz_pkg::icz_mac_ctl_t         ctl,
    input  logic [PIXEL_BITS-1:0]         ring_q,
    input  logic [icz_pkg::COEF_W-1:0]    coef_q,
    output logic [PIXEL_BITS-1:0]         result
);
    import icz_pkg::*;

    localparam int PROD_W = PIXEL_BITS + COEF_W;
    localparam int ACC_W  = PROD_W + 9;
    localparam logic [ACC_W-1:0] RND  = (ACC_W'(1) << COEF_FRAC) - ACC_W'(1);
    localparam logic [ACC_W-1:0] MAXV = (ACC_W'(1) << (PIXEL_BITS - 1)) - ACC_W'(1);
    localparam logic [ACC_W-1:0] MINV = ~MAXV;

    logic signed [PROD_W-1:0] prod_reg;
    logic                     live2_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  adj;
    logic signed [ACC_W-1:0]  scaled;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            live2_reg <= 1'b0;
        else
            live2_reg <= ctl.live;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= ctl.live ? PROD_W'($signed(ring_q) * $signed(coef_q)) : '0;
        if (ctl.acc_clear)
            acc_reg <= '0;
        else if (live2_reg)
            acc_reg <= acc_reg + ACC_W'(prod_reg);
    end

    // truncate toward zero: bias negative sums before the arithmetic shift
    always_comb
    begin
        adj    = acc_reg + (acc_reg[ACC_W-1] ? $signed(RND) : $signed(ACC_W'(0)));
        scaled = adj >>> COEF_FRAC;
        if (scaled > $signed(MAXV))
            result = MAXV[PIXEL_BITS-1:0];
        else if (scaled < $signed(MINV))
            result = MINV[PIXEL_BITS-1:0];
        else
            result = scaled[PIXEL_BITS-1:0];
    end

endmodule

### hw/rtl/image_convolution_zero_padded.sv
// ============================================================================
// image_convolution_zero_padded
// Streaming zero-padded 3D convolution with a ring store and one MAC.
// ============================================================================
// Items arrive in raster order (x fastest, then y, then z). A coefficient
// item writes the kernel memory. A pixel or flush item writes the
// 32768-entry sample ring; when it completes the neighborhood of the next
// output position the block walks the kernel with one multiply-accumulate
// per tap out of the ring and kernel memories, taking no further item until
// the walk is done. Out-of-volume taps are skipped but still advance the
// kernel index. The finished sample sits in an output register, so the next
// item is taken while it waits. After reset the kernel memory is rewritten
// to the 3x3 identity in a clearing pass over all KERNEL_MAX cubed entries
// during which no item is taken; after any register write no item is taken
// until the derived geometry has settled. A register write restarts the
// volume.
// ============================================================================
module image_convolution_zero_padded #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64,
    parameter int KERNEL_MAX = 7,
    parameter int COEF_FRAC  = 12,
    parameter int PIXEL_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [icz_pkg::ADDR_W-1:0]      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    // item input
    input  logic                            item_valid,
    output logic                            item_stall,
    input  logic [1:0]                      mode,
    input  logic [icz_pkg::CIDX_W-1:0]      coef_index,
    input  logic signed [icz_pkg::COEF_IN_W-1:0] coef_value,
    input  logic signed [PIXEL_BITS-1:0]    pixel_in,
    // result output
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic signed [PIXEL_BITS-1:0]    pixel_out,
    output logic                            frame_end
);
    import icz_pkg::*;

    localparam int COEF_DEPTH = KERNEL_MAX * KERNEL_MAX * KERNEL_MAX;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    icz_geom_t    geom;
    icz_wr_t      wr;
    icz_tap_t     tap;
    icz_mac_ctl_t mac_ctl;
    logic         cfg_wr;
    logic         clr_busy;
    logic         live_q;
    logic [PIXEL_BITS-1:0] ring_q;
    logic [COEF_W-1:0]     coef_q;
    logic [PIXEL_BITS-1:0] mac_result;

    logic [1:0]   state_reg, state_next;
    logic [2:0]   settle_reg;
    logic [1:0]   drain_reg, drain_next;
    logic [POS_W-1:0]   in_pos_reg, in_pos_next;
    logic [POS_W-1:0]   out_pos_reg, out_pos_next;
    logic [DIM_W-1:0]   ox_reg, ox_next, oy_reg, oy_next;
    logic [DEPTH_W-1:0] oz_reg, oz_next;
    logic [KS_W-1:0]    tx_reg, tx_next, ty_reg, ty_next, tz_reg, tz_next;
    logic [CIDX_W-1:0]  k_reg, k_next;
    logic signed [8:0]  xx_reg, xx_next, x0_reg, x0_next;
    logic signed [8:0]  yy_reg, yy_next, y0_reg, y0_next;
    logic signed [14:0] zz_reg, zz_next;
    logic [RING_AW-1:0] q_reg, q_next, qrow_reg, qrow_next, qslab_reg, qslab_next;
    logic               out_valid_reg;
    logic [PIXEL_BITS-1:0] pixel_out_reg;
    logic               frame_end_reg;

    logic accept, is_sample, need_out, start, empty, inb, out_free, last_out;
    logic signed [8:0]  x_init, y_init;
    logic signed [14:0] z_init;
    logic [RING_AW-1:0] q_init;

    icz_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg_wr  (cfg_wr),
        .geom    (geom)
    );

    icz_store #(
        .KERNEL_MAX (KERNEL_MAX),
        .COEF_FRAC  (COEF_FRAC),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (wr),
        .ring_wd  ((mode == MODE_PIXEL) ? pixel_in : '0),
        .coef_wd  (coef_value),
        .tap      (tap),
        .ring_q   (ring_q),
        .coef_q   (coef_q),
        .live_q   (live_q),
        .clr_busy (clr_busy)
    );

    icz_mac #(
        .COEF_FRAC  (COEF_FRAC),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mac_ctl),
        .ring_q (ring_q),
        .coef_q (coef_q),
        .result (mac_result)
    );

    // Take items only when idle, settled and past the clearing pass
    assign item_stall = !(state_reg == S_IDLE && settle_reg == '0 && !clr_busy);
    assign accept     = item_valid && !item_stall;
    assign is_sample  = (mode == MODE_PIXEL) || (mode == MODE_FLUSH);

    // Release an output once every in-volume sample it needs has arrived
    assign need_out = (in_pos_reg >= POS_W'(geom.total_m1)) ||
                      (in_pos_reg >= out_pos_reg + POS_W'(geom.reach));
    assign start    = accept && is_sample && need_out;
    assign empty    = (geom.sx == '0) || (geom.sy == '0) || (geom.sz == '0);

    assign x_init = $signed({2'b00, ox_reg}) - $signed({7'd0, geom.hx});
    assign y_init = $signed({2'b00, oy_reg}) - $signed({7'd0, geom.hy});
    assign z_init = $signed({2'b00, oz_reg}) - $signed({13'd0, geom.hz});
    assign q_init = out_pos_reg[RING_AW-1:0] - geom.back[RING_AW-1:0];

    // Tap inside the volume
    assign inb = (xx_reg >= 0) && (xx_reg < $signed({2'b00, geom.w})) &&
                 (yy_reg >= 0) && (yy_reg < $signed({2'b00, geom.h})) &&
                 (zz_reg >= 0) && (zz_reg < $signed({2'b00, geom.d}));

    // Memory writes: ring on sample items, kernel on coefficient items
    always_comb
    begin
        wr.ring_we   = accept && is_sample;
        wr.ring_addr = in_pos_reg[RING_AW-1:0];
        wr.coef_we   = accept && (mode == MODE_COEF) &&
                       (coef_index < CIDX_W'(COEF_DEPTH));
        wr.coef_addr = coef_index;
    end

    // Tap read: skip out-of-volume taps and indexes beyond the kernel memory
    always_comb
    begin
        tap.live      = (state_reg == S_RUN) && inb && (k_reg < CIDX_W'(COEF_DEPTH));
        tap.ring_addr = q_reg;
        tap.coef_addr = k_reg;
        mac_ctl.acc_clear = start;
        mac_ctl.live      = live_q;
    end

    assign out_free = !out_valid_reg || !result_stall;
    assign last_out = (out_pos_reg == POS_W'(geom.total_m1));

    always_comb
    begin
        state_next   = state_reg;
        drain_next   = drain_reg;
        in_pos_next  = in_pos_reg;
        out_pos_next = out_pos_reg;
        ox_next      = ox_reg;
        oy_next      = oy_reg;
        oz_next      = oz_reg;
        tx_next      = tx_reg;
        ty_next      = ty_reg;
        tz_next      = tz_reg;
        k_next       = k_reg;
        xx_next      = xx_reg;
        yy_next      = yy_reg;
        zz_next      = zz_reg;
        x0_next      = x0_reg;
        y0_next      = y0_reg;
        q_next       = q_reg;
        qrow_next    = qrow_reg;
        qslab_next   = qslab_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept && is_sample)
                    in_pos_next = in_pos_reg + POS_W'(1);
                if (start)
                begin
                    tx_next    = '0;
                    ty_next    = '0;
                    tz_next    = '0;
                    k_next     = '0;
                    x0_next    = x_init;
                    y0_next    = y_init;
                    xx_next    = x_init;
                    yy_next    = y_init;
                    zz_next    = z_init;
                    q_next     = q_init;
                    qrow_next  = q_init;
                    qslab_next = q_init;
                    drain_next = 2'd2;
                    state_next = empty ? S_DRAIN : S_RUN;
                end
            end
            S_RUN:
            begin
                // advance every tap; x, then y, then z
                k_next = k_reg + CIDX_W'(1);
                if (tx_reg != geom.sx - 3'd1)
                begin
                    tx_next = tx_reg + 3'd1;
                    xx_next = xx_reg + 9'sd1;
                    q_next  = q_reg + RING_AW'(1);
                end
                else if (ty_reg != geom.sy - 3'd1)
                begin
                    tx_next   = '0;
                    ty_next   = ty_reg + 3'd1;
                    xx_next   = x0_reg;
                    yy_next   = yy_reg + 9'sd1;
                    qrow_next = qrow_reg + RING_AW'(geom.w);
                    q_next    = qrow_reg + RING_AW'(geom.w);
                end
                else if (tz_reg != geom.sz - 3'd1)
                begin
                    tx_next    = '0;
                    ty_next    = '0;
                    tz_next    = tz_reg + 3'd1;
                    xx_next    = x0_reg;
                    yy_next    = y0_reg;
                    zz_next    = zz_reg + 15'sd1;
                    qslab_next = qslab_reg + RING_AW'(geom.plane);
                    qrow_next  = qslab_reg + RING_AW'(geom.plane);
                    q_next     = qslab_reg + RING_AW'(geom.plane);
                end
                else
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // wait out the memory read, product and accumulate stages
                if (drain_reg == '0)
                    state_next = S_DONE;
                else
                    drain_next = drain_reg - 2'd1;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                    if (last_out)
                    begin
                        in_pos_next  = '0;
                        out_pos_next = '0;
                        ox_next      = '0;
                        oy_next      = '0;
                        oz_next      = '0;
                    end
                    else
                    begin
                        out_pos_next = out_pos_reg + POS_W'(1);
                        if (ox_reg != geom.w - 7'd1)
                            ox_next = ox_reg + 7'd1;
                        else
                        begin
                            ox_next = '0;
                            if (oy_reg != geom.h - 7'd1)
                                oy_next = oy_reg + 7'd1;
                            else
                            begin
                                oy_next = '0;
                                oz_next = oz_reg + 13'd1;
                            end
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // a register write restarts the volume
        if (cfg_wr)
        begin
            in_pos_next  = '0;
            out_pos_next = '0;
            ox_next      = '0;
            oy_next      = '0;
            oz_next      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            settle_reg    <= 3'd4;
            drain_reg     <= '0;
            in_pos_reg    <= '0;
            out_pos_reg   <= '0;
            ox_reg        <= '0;
            oy_reg        <= '0;
            oz_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            drain_reg   <= drain_next;
            in_pos_reg  <= in_pos_next;
            out_pos_reg <= out_pos_next;
            ox_reg      <= ox_next;
            oy_reg      <= oy_next;
            oz_reg      <= oz_next;
            if (cfg_wr)
                settle_reg <= 3'd4;
            else if (settle_reg != '0)
                settle_reg <= settle_reg - 3'd1;
            if (state_reg == S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        tx_reg    <= tx_next;
        ty_reg    <= ty_next;
        tz_reg    <= tz_next;
        k_reg     <= k_next;
        xx_reg    <= xx_next;
        yy_reg    <= yy_next;
        zz_reg    <= zz_next;
        x0_reg    <= x0_next;
        y0_reg    <= y0_next;
        q_reg     <= q_next;
        qrow_reg  <= qrow_next;
        qslab_reg <= qslab_next;
        // hold the result while it is stalled
        if (state_reg == S_DONE && out_free)
        begin
            pixel_out_reg <= mac_result;
            frame_end_reg <= last_out;
        end
    end

    assign result_valid = out_valid_reg;
    assign pixel_out    = $signed(pixel_out_reg);
    assign frame_end    = frame_end_reg;

    // A new result only comes out of the finishing state
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg == S_DONE))
        else $error("result raised outside finishing state");

    // No item is taken while a kernel walk is in flight
    a_stall_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> item_stall)
        else $error("item taken while busy");

    // The tap index never runs past the largest kernel
    a_tap_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> (k_reg < CIDX_W'(343)))
        else $error("tap index out of range");

    // After the last sample of a volume both positions restart
    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_free && last_out && !cfg_wr)
        |=> (out_pos_reg == '0 && in_pos_reg == '0))
        else $error("positions not cleared at frame end");

endmodule
